FILE: src/rgab_pkg.sv
// Shared types and constants for the radial glow blend pipeline.
`timescale 1ns / 1ps

package rgab_pkg;

  // Default raster size
  localparam int IMAGE_WIDTH_DEF  = 1280;
  localparam int IMAGE_HEIGHT_DEF = 720;

  // Configuration register indexes
  localparam logic [2:0] REG_CENTER_X    = 3'd0;
  localparam logic [2:0] REG_CENTER_Y    = 3'd1;
  localparam logic [2:0] REG_GLOW_RADIUS = 3'd2;
  localparam logic [2:0] REG_GLOW_RED    = 3'd3;
  localparam logic [2:0] REG_GLOW_GREEN  = 3'd4;
  localparam logic [2:0] REG_GLOW_BLUE   = 3'd5;
  localparam logic [2:0] REG_PEAK_ALPHA  = 3'd6;

  // Register reset values
  localparam logic [11:0] CENTER_X_RST = 12'd640;
  localparam logic [11:0] CENTER_Y_RST = 12'd360;

  // Root and divide cell counts
  localparam int SQRT_CELLS = 13;
  localparam int DIV_CELLS  = 9;

  // Work item carried down the chain
  typedef struct packed {
    logic        act;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] dx;
    logic [11:0] dy;
    logic [23:0] dxsq;
    logic [23:0] dysq;
    logic [25:0] v;
    logic [25:0] root;
    logic [11:0] rem;
    logic [20:0] num;
    logic [8:0]  quo;
  } pkt_t;

endpackage

FILE: src/rgab_in_if.sv
// Pixel input channel: valid/ready with coordinates and color.
`timescale 1ns / 1ps

interface rgab_in_if;
  logic       valid;
  logic       ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;

  modport source (output valid, pixel_x, pixel_y, in_red, in_green, in_blue, input ready);
  modport sink (input valid, pixel_x, pixel_y, in_red, in_green, in_blue, output ready);
endinterface

FILE: src/rgab_out_if.sv
// Pixel result channel: valid/ready with blended color.
`timescale 1ns / 1ps

interface rgab_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

FILE: src/rgab_sqrt_cell.sv
// One digit cell of the pipelined floor square root.
`timescale 1ns / 1ps

module rgab_sqrt_cell
  import rgab_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic valid_i,
  input  pkt_t pkt_i,
  output logic ready_o,
  output logic valid_o,
  output pkt_t pkt_o,
  input  logic ready_i
);

  localparam logic [25:0] BIT_VAL = 26'(1) << SHIFT;

  logic        valid_r;
  pkt_t        pkt_r;
  pkt_t        pkt_nxt;
  logic [25:0] trial;

  // Restoring root step on one bit pair
  always_comb begin
    pkt_nxt = pkt_i;
    trial   = pkt_i.root + BIT_VAL;
    if (pkt_i.v >= trial) begin
      pkt_nxt.v    = pkt_i.v - trial;
      pkt_nxt.root = (pkt_i.root >> 1) + BIT_VAL;
    end else begin
      pkt_nxt.root = pkt_i.root >> 1;
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign valid_o = valid_r;
  assign pkt_o   = pkt_r;

endmodule

FILE: src/rgab_div_cell.sv
// One quotient-bit cell of the pipelined restoring divider.
`timescale 1ns / 1ps

module rgab_div_cell
  import rgab_pkg::*;
#(
  parameter int QBIT = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [11:0] radius,
  input  logic        valid_i,
  input  pkt_t        pkt_i,
  output logic        ready_o,
  output logic        valid_o,
  output pkt_t        pkt_o,
  input  logic        ready_i
);

  logic        valid_r;
  pkt_t        pkt_r;
  pkt_t        pkt_nxt;
  logic [12:0] rem2;

  // Shift in next numerator bit, subtract divisor if it fits
  always_comb begin
    pkt_nxt = pkt_i;
    rem2    = {pkt_i.rem, pkt_i.num[QBIT]};
    if (rem2 >= {1'b0, radius}) begin
      pkt_nxt.rem       = 12'(rem2 - {1'b0, radius});
      pkt_nxt.quo[QBIT] = 1'b1;
    end else begin
      pkt_nxt.rem = rem2[11:0];
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign valid_o = valid_r;
  assign pkt_o   = pkt_r;

endmodule

FILE: src/radial_glow_additive_blend.sv
// Top level: radial additive glow over a pixel stream.
//
// in_ch carries one pixel per transaction (pixel_x, pixel_y, in_red/green/blue);
// out_ch returns the blended pixel, one result per input, in order.
// Both use valid/ready; a transaction happens when both are high at clk.
// cfg_we/cfg_idx/cfg_data write the seven glow registers; write only while idle.
//
// The pipeline is distance (3 stages), a chain of 13 root cells, the
// alpha multiply, a chain of 9 divider cells and the blend/output register.
// Throughput is one pixel per cycle while out_ch is ready; every stage holds
// its own valid bit, so bubbles close up and a new pixel is taken while a
// result waits at out_ch. When out_ch stalls, stages fill up from the output
// back; in_ch.ready falls only once every stage holds a pixel.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults: center 640,360, radius 0 (glow off), colors and peak 0.
`timescale 1ns / 1ps

module radial_glow_additive_blend
  import rgab_pkg::*;
#(
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [11:0] cfg_data,
  rgab_in_if.sink     in_ch,
  rgab_out_if.source  out_ch
);

  localparam logic [12:0] WIDTH_L  = 13'(IMAGE_WIDTH);
  localparam logic [12:0] HEIGHT_L = 13'(IMAGE_HEIGHT);

  // Configuration registers
  logic [11:0] center_x_r, center_y_r, radius_r;
  logic [7:0]  glow_red_r, glow_green_r, glow_blue_r;
  logic [8:0]  peak_r;
  logic [23:0] rsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= CENTER_X_RST;
      center_y_r   <= CENTER_Y_RST;
      radius_r     <= '0;
      glow_red_r   <= '0;
      glow_green_r <= '0;
      glow_blue_r  <= '0;
      peak_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CENTER_X:    center_x_r   <= cfg_data;
        REG_CENTER_Y:    center_y_r   <= cfg_data;
        REG_GLOW_RADIUS: radius_r     <= cfg_data;
        REG_GLOW_RED:    glow_red_r   <= cfg_data[7:0];
        REG_GLOW_GREEN:  glow_green_r <= cfg_data[7:0];
        REG_GLOW_BLUE:   glow_blue_r  <= cfg_data[7:0];
        REG_PEAK_ALPHA:  peak_r       <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Radius squared, refreshed every cycle from the register
  always_ff @(posedge clk) begin
    rsq_r <= radius_r * radius_r;
  end

  // Stage 0: offsets, in-image check and nonzero-radius check
  logic v0_r, rdy0;
  pkt_t p0_r, p0_nxt;
  logic rdy1;

  always_comb begin
    p0_nxt       = '0;
    p0_nxt.act   = (radius_r != 12'd0) && ({1'b0, in_ch.pixel_x} < WIDTH_L) &&
                   ({1'b0, in_ch.pixel_y} < HEIGHT_L);
    p0_nxt.red   = in_ch.in_red;
    p0_nxt.green = in_ch.in_green;
    p0_nxt.blue  = in_ch.in_blue;
    p0_nxt.dx    = (in_ch.pixel_x >= center_x_r) ? in_ch.pixel_x - center_x_r
                                                 : center_x_r - in_ch.pixel_x;
    p0_nxt.dy    = (in_ch.pixel_y >= center_y_r) ? in_ch.pixel_y - center_y_r
                                                 : center_y_r - in_ch.pixel_y;
  end

  assign rdy0        = !v0_r || rdy1;
  assign in_ch.ready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy0) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_ch.valid) begin
      p0_r <= p0_nxt;
    end
  end

  // Stage 1: squares of the offsets
  logic v1_r;
  pkt_t p1_r, p1_nxt;
  logic rdy2;

  always_comb begin
    p1_nxt      = p0_r;
    p1_nxt.dxsq = p0_r.dx * p0_r.dx;
    p1_nxt.dysq = p0_r.dy * p0_r.dy;
  end

  assign rdy1 = !v1_r || rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && v0_r) begin
      p1_r <= p1_nxt;
    end
  end

  // Stage 2: squared distance and circle test, seed the root
  logic        v2_r;
  pkt_t        p2_r, p2_nxt;
  logic [24:0] dsq;
  logic        rdy_sq0;

  always_comb begin
    dsq         = {1'b0, p1_r.dxsq} + {1'b0, p1_r.dysq};
    p2_nxt      = p1_r;
    p2_nxt.act  = p1_r.act && (dsq < {1'b0, rsq_r});
    p2_nxt.v    = {1'b0, dsq};
    p2_nxt.root = '0;
  end

  assign rdy2 = !v2_r || rdy_sq0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      p2_r <= p2_nxt;
    end
  end

  // Root chain
  logic sq_v   [SQRT_CELLS+1];
  pkt_t sq_p   [SQRT_CELLS+1];
  logic sq_rdy [SQRT_CELLS+1];

  assign sq_v[0]  = v2_r;
  assign sq_p[0]  = p2_r;
  assign rdy_sq0  = sq_rdy[0];

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    rgab_sqrt_cell #(.SHIFT(2 * (SQRT_CELLS - 1 - k))) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (sq_v[k]),
      .pkt_i   (sq_p[k]),
      .ready_o (sq_rdy[k]),
      .valid_o (sq_v[k+1]),
      .pkt_o   (sq_p[k+1]),
      .ready_i (sq_rdy[k+1])
    );
  end

  // Alpha numerator: (radius - dist) * peak
  logic        vm_r, rdym;
  pkt_t        pm_r, pm_nxt;
  logic [11:0] diff;
  logic        rdy_dv0;

  always_comb begin
    diff       = radius_r - sq_p[SQRT_CELLS].root[11:0];
    pm_nxt     = sq_p[SQRT_CELLS];
    pm_nxt.num = 21'(diff) * 21'(peak_r);
    pm_nxt.rem = pm_nxt.num[20:9];
    pm_nxt.quo = '0;
  end

  assign rdym               = !vm_r || rdy_dv0;
  assign sq_rdy[SQRT_CELLS] = rdym;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (rdym) begin
      vm_r <= sq_v[SQRT_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdym && sq_v[SQRT_CELLS]) begin
      pm_r <= pm_nxt;
    end
  end

  // Divider chain
  logic dv_v   [DIV_CELLS+1];
  pkt_t dv_p   [DIV_CELLS+1];
  logic dv_rdy [DIV_CELLS+1];

  assign dv_v[0] = vm_r;
  assign dv_p[0] = pm_r;
  assign rdy_dv0 = dv_rdy[0];

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    rgab_div_cell #(.QBIT(DIV_CELLS - 1 - k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .radius  (radius_r),
      .valid_i (dv_v[k]),
      .pkt_i   (dv_p[k]),
      .ready_o (dv_rdy[k]),
      .valid_o (dv_v[k+1]),
      .pkt_o   (dv_p[k+1]),
      .ready_i (dv_rdy[k+1])
    );
  end

  // Blend and output register
  logic        vo_r, rdyo;
  logic [7:0]  ored_r, ogrn_r, oblu_r;
  logic [8:0]  alpha;
  logic [16:0] pr, pg, pb;
  logic [9:0]  sr, sg, sb;
  pkt_t        pf;

  assign pf = dv_p[DIV_CELLS];

  always_comb begin
    alpha = (pf.quo > peak_r) ? peak_r : pf.quo;
    pr    = 17'(glow_red_r) * 17'(alpha);
    pg    = 17'(glow_green_r) * 17'(alpha);
    pb    = 17'(glow_blue_r) * 17'(alpha);
    sr    = 10'(pf.red) + 10'(pr[16:8]);
    sg    = 10'(pf.green) + 10'(pg[16:8]);
    sb    = 10'(pf.blue) + 10'(pb[16:8]);
  end

  assign rdyo              = !vo_r || out_ch.ready;
  assign dv_rdy[DIV_CELLS] = rdyo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (rdyo) begin
      vo_r <= dv_v[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdyo && dv_v[DIV_CELLS]) begin
      if (pf.act) begin
        ored_r <= (sr > 10'd255) ? 8'hFF : sr[7:0];
        ogrn_r <= (sg > 10'd255) ? 8'hFF : sg[7:0];
        oblu_r <= (sb > 10'd255) ? 8'hFF : sb[7:0];
      end else begin
        ored_r <= pf.red;
        ogrn_r <= pf.green;
        oblu_r <= pf.blue;
      end
    end
  end

  assign out_ch.valid     = vo_r;
  assign out_ch.out_red   = ored_r;
  assign out_ch.out_green = ogrn_r;
  assign out_ch.out_blue  = oblu_r;

  // Input only backs up when the whole chain is full and the output is held
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without a held result");

  // Root of a 25-bit value fits in 13 bits
  a_root_width: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v[SQRT_CELLS] |-> (sq_p[SQRT_CELLS].root[25:13] == '0))
    else $error("root out of range");

  // Quotient never exceeds the peak weight for a glowing pixel
  a_quo_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_v[DIV_CELLS] && pf.act) |-> (pf.quo <= peak_r))
    else $error("alpha above peak");

endmodule
